FILE: design/brf_pkg.sv
// ----------------------------------------------------------------------------
// brf_pkg
// Shared types, widths and codes for the byte ring FIFO with peek and skip.
// ----------------------------------------------------------------------------
package brf_pkg;

   // default store depth in bytes
   localparam int DEPTH_DEFAULT = 4096;

   // field widths
   localparam int ACT_W  = 3;
   localparam int BYTE_W = 8;
   localparam int CNT_W  = 13;

   // action codes
   localparam logic [ACT_W-1:0] ACT_PUSH    = 3'd0;
   localparam logic [ACT_W-1:0] ACT_POP     = 3'd1;
   localparam logic [ACT_W-1:0] ACT_PEEK    = 3'd2;
   localparam logic [ACT_W-1:0] ACT_SKIP    = 3'd3;
   localparam logic [ACT_W-1:0] ACT_SKIP_TO = 3'd4;
   localparam logic [ACT_W-1:0] ACT_CLEAR   = 3'd5;

   // register port
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic REG_RING_SIZE = 1'b0;
   localparam logic [CNT_W-1:0] RING_SIZE_RESET = 13'd4096;

endpackage

FILE: design/brf_mem.sv
// ----------------------------------------------------------------------------
// brf_mem
// Byte store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module brf_mem import brf_pkg::*; #(
   parameter int DEPTH  = DEPTH_DEFAULT,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [BYTE_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [BYTE_W-1:0] rd_data
);

   logic [BYTE_W-1:0] store_mem [DEPTH];
   logic [BYTE_W-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_mem[wr_addr] <= wr_data;
      end
   end

   // read port, data held until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= store_mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: design/brf_mod.sv
// ----------------------------------------------------------------------------
// brf_mod
// Bit-serial restoring remainder unit: dividend mod divisor, one bit a cycle.
// ----------------------------------------------------------------------------
module brf_mod import brf_pkg::*; #(
   parameter int W = CNT_W
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic [W-1:0] dividend,
   input  logic [W-1:0] divisor,
   output logic         done,
   output logic [W-1:0] remainder
);

   localparam int STEP_W = $clog2(W + 1);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [W-1:0]      rem_ff, rem_in;
   logic [W-1:0]      dvd_ff, dvd_in;
   logic [W-1:0]      dsr_ff, dsr_in;
   logic [W:0]        trial;

   // one restoring step
   always_comb begin
      trial = {rem_ff, dvd_ff[W-1]};
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      rem_in  = rem_ff;
      dvd_in  = dvd_ff;
      dsr_in  = dsr_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = STEP_W'(W);
         rem_in  = '0;
         dvd_in  = dividend;
         dsr_in  = divisor;
      end else if (busy_ff) begin
         if (trial >= {1'b0, dsr_ff}) begin
            rem_in = W'(trial - {1'b0, dsr_ff});
         end else begin
            rem_in = trial[W-1:0];
         end
         dvd_in  = {dvd_ff[W-2:0], 1'b0};
         step_in = step_ff - 1'b1;
         if (step_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dvd_ff <= dvd_in;
      dsr_ff <= dsr_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

FILE: design/byte_ring_fifo_with_peek_skip_top.sv
// Sequence: an accepted request runs in the execute state; skip-to then waits in the
// modulo state for the bit-serial modulo unit; the finish state registers the result.
// New requests are taken only while idle or as the last result is issued; pop and
// peek read the store, whose read data is registered; skip-to holds off new requests.
// Reset: synchronous, clears pointers and fill level, size register to 4096 bytes;
// the byte store is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
// byte_ring_fifo_with_peek_skip_top
// Byte circular FIFO with push, pop, peek, skip, skip-to and clear actions.
// ----------------------------------------------------------------------------
module byte_ring_fifo_with_peek_skip_top import brf_pkg::*; #(
   parameter int DEPTH = DEPTH_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   // request channel
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [ACT_W-1:0]      req_action,
   input  logic [BYTE_W-1:0]     req_data_in,
   input  logic [CNT_W-1:0]      req_operand_value,
   // response channel
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [BYTE_W-1:0]     rsp_data_out,
   output logic                  rsp_ok,
   output logic [CNT_W-1:0]      rsp_skipped,
   output logic [CNT_W-1:0]      rsp_level,
   output logic [CNT_W-1:0]      rsp_space,
   // register port
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   localparam int ADDR_W = $clog2(DEPTH);
   localparam int IDX_W  = (ADDR_W < CNT_W) ? ADDR_W : CNT_W;

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_EXEC   = 2'd1;
   localparam logic [1:0] ST_MOD    = 2'd2;
   localparam logic [1:0] ST_FINISH = 2'd3;

   logic [1:0]        state_ff, state_in;
   logic [ACT_W-1:0]  act_ff, act_in;
   logic [BYTE_W-1:0] din_ff, din_in;
   logic [CNT_W-1:0]  opv_ff, opv_in;
   logic [IDX_W-1:0]  read_ff, read_in;
   logic [IDX_W-1:0]  write_ff, write_in;
   logic [CNT_W-1:0]  fill_ff, fill_in;
   logic [CNT_W-1:0]  ring_ff, ring_in;
   logic              pend_ok_ff, pend_ok_in;
   logic              pend_rd_ff, pend_rd_in;
   logic [CNT_W-1:0]  pend_skip_ff, pend_skip_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [BYTE_W-1:0] rsp_data_ff, rsp_data_in;
   logic              rsp_ok_ff, rsp_ok_in;
   logic [CNT_W-1:0]  rsp_skip_ff, rsp_skip_in;
   logic [CNT_W-1:0]  rsp_level_ff, rsp_level_in;
   logic [CNT_W-1:0]  rsp_space_ff, rsp_space_in;

   logic              req_accept;
   logic              out_free;
   logic              csr_write;
   logic [CNT_W-1:0]  sz;
   logic [CNT_W-1:0]  read_ext;
   logic [CNT_W-1:0]  skip_gap;
   logic [CNT_W-1:0]  disc_n;
   logic [CNT_W-1:0]  disc_sat;
   logic [IDX_W-1:0]  disc_read;
   logic [IDX_W-1:0]  peek_idx;

   logic              mem_wr_en;
   logic              mem_rd_en;
   logic [IDX_W-1:0]  mem_rd_idx;
   logic [BYTE_W-1:0] mem_rd_data;
   logic              mod_start;
   logic              mod_done;
   logic [CNT_W-1:0]  mod_rem;

   // index advance around the ring, a < size and b <= size
   function automatic logic [IDX_W-1:0] wrap_add(
      input logic [IDX_W-1:0] a,
      input logic [CNT_W-1:0] b,
      input logic [CNT_W-1:0] size
   );
      logic [CNT_W:0] s;
      s = (CNT_W+1)'(a) + (CNT_W+1)'(b);
      if (s >= {1'b0, size}) begin
         s = s - {1'b0, size};
      end
      return IDX_W'(s);
   endfunction

   // handshakes
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign req_stall  = !((state_ff == ST_IDLE) || ((state_ff == ST_FINISH) && out_free));
   assign req_accept = req_valid && !req_stall;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite &&
                       (csr_paddr[CSR_ADDR_W-1] == REG_RING_SIZE);
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[CSR_ADDR_W-1] == REG_RING_SIZE) ?
                       CSR_DATA_W'(ring_ff) : '0;

   // effective ring size, zero as one and clamped to the store depth
   always_comb begin
      if (ring_ff == '0) begin
         sz = CNT_W'(1);
      end else if (32'(ring_ff) > DEPTH) begin
         sz = CNT_W'(DEPTH);
      end else begin
         sz = ring_ff;
      end
   end

   // skip-to distance from the read point forward to the target
   assign read_ext = CNT_W'(read_ff);
   always_comb begin
      if (mod_rem >= read_ext) begin
         skip_gap = mod_rem - read_ext;
      end else begin
         skip_gap = CNT_W'((CNT_W+1)'(mod_rem) + (CNT_W+1)'(sz) - (CNT_W+1)'(read_ext));
      end
   end

   // shared discard, saturated at the fill level
   assign disc_n    = (state_ff == ST_MOD) ? skip_gap : opv_ff;
   assign disc_sat  = (disc_n > fill_ff) ? fill_ff : disc_n;
   assign disc_read = wrap_add(read_ff, disc_sat, sz);
   assign peek_idx  = wrap_add(read_ff, opv_ff, sz);

   // sequencer and state update
   always_comb begin
      state_in     = state_ff;
      act_in       = act_ff;
      din_in       = din_ff;
      opv_in       = opv_ff;
      read_in      = read_ff;
      write_in     = write_ff;
      fill_in      = fill_ff;
      ring_in      = ring_ff;
      pend_ok_in   = pend_ok_ff;
      pend_rd_in   = pend_rd_ff;
      pend_skip_in = pend_skip_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      rsp_ok_in    = rsp_ok_ff;
      rsp_skip_in  = rsp_skip_ff;
      rsp_level_in = rsp_level_ff;
      rsp_space_in = rsp_space_ff;
      mem_wr_en    = 1'b0;
      mem_rd_en    = 1'b0;
      mem_rd_idx   = read_ff;
      mod_start    = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            pend_ok_in   = 1'b0;
            pend_rd_in   = 1'b0;
            pend_skip_in = '0;
            state_in     = ST_FINISH;
            case (act_ff)
               ACT_PUSH: begin
                  if (fill_ff < sz) begin
                     mem_wr_en  = 1'b1;
                     write_in   = wrap_add(write_ff, CNT_W'(1), sz);
                     fill_in    = fill_ff + 1'b1;
                     pend_ok_in = 1'b1;
                  end
               end
               ACT_POP: begin
                  if (fill_ff != '0) begin
                     mem_rd_en  = 1'b1;
                     read_in    = wrap_add(read_ff, CNT_W'(1), sz);
                     fill_in    = fill_ff - 1'b1;
                     pend_ok_in = 1'b1;
                     pend_rd_in = 1'b1;
                  end
               end
               ACT_PEEK: begin
                  if (opv_ff < fill_ff) begin
                     mem_rd_en  = 1'b1;
                     mem_rd_idx = peek_idx;
                     pend_ok_in = 1'b1;
                     pend_rd_in = 1'b1;
                  end
               end
               ACT_SKIP: begin
                  read_in      = disc_read;
                  fill_in      = fill_ff - disc_sat;
                  pend_skip_in = disc_sat;
               end
               ACT_SKIP_TO: begin
                  mod_start = 1'b1;
                  state_in  = ST_MOD;
               end
               ACT_CLEAR: begin
                  read_in  = '0;
                  write_in = '0;
                  fill_in  = '0;
               end
               default: begin
               end
            endcase
         end
         ST_MOD: begin
            if (mod_done) begin
               read_in      = disc_read;
               fill_in      = fill_ff - disc_sat;
               pend_skip_in = disc_sat;
               state_in     = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = pend_rd_ff ? mem_rd_data : '0;
               rsp_ok_in    = pend_ok_ff;
               rsp_skip_in  = pend_skip_ff;
               rsp_level_in = fill_ff;
               rsp_space_in = sz - fill_ff;
               state_in     = req_accept ? ST_EXEC : ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // capture a new request beat
      if (req_accept) begin
         act_in = req_action;
         din_in = req_data_in;
         opv_in = req_operand_value;
      end

      // size write empties the ring
      if (csr_write) begin
         ring_in  = csr_pwdata[CNT_W-1:0];
         read_in  = '0;
         write_in = '0;
         fill_in  = '0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         read_ff      <= '0;
         write_ff     <= '0;
         fill_ff      <= '0;
         ring_ff      <= RING_SIZE_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         read_ff      <= read_in;
         write_ff     <= write_in;
         fill_ff      <= fill_in;
         ring_ff      <= ring_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      act_ff       <= act_in;
      din_ff       <= din_in;
      opv_ff       <= opv_in;
      pend_ok_ff   <= pend_ok_in;
      pend_rd_ff   <= pend_rd_in;
      pend_skip_ff <= pend_skip_in;
      rsp_data_ff  <= rsp_data_in;
      rsp_ok_ff    <= rsp_ok_in;
      rsp_skip_ff  <= rsp_skip_in;
      rsp_level_ff <= rsp_level_in;
      rsp_space_ff <= rsp_space_in;
   end

   // byte store
   brf_mem #(
      .DEPTH  (DEPTH),
      .ADDR_W (ADDR_W)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (ADDR_W'(write_ff)),
      .wr_data (din_ff),
      .rd_en   (mem_rd_en),
      .rd_addr (ADDR_W'(mem_rd_idx)),
      .rd_data (mem_rd_data)
   );

   // skip-to target modulo ring size
   brf_mod #(
      .W (CNT_W)
   ) u_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (mod_start),
      .dividend  (opv_ff),
      .divisor   (sz),
      .done      (mod_done),
      .remainder (mod_rem)
   );

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_data_out = rsp_data_ff;
   assign rsp_ok       = rsp_ok_ff;
   assign rsp_skipped  = rsp_skip_ff;
   assign rsp_level    = rsp_level_ff;
   assign rsp_space    = rsp_space_ff;

endmodule

FILE: design/brf_checker.sv
// ----------------------------------------------------------------------------
// brf_checker
// Port-level checks on the response channel of the byte ring FIFO.
// ----------------------------------------------------------------------------
module brf_checker import brf_pkg::*; (
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input logic [BYTE_W-1:0] rsp_data_out,
   input logic              rsp_ok,
   input logic [CNT_W-1:0]  rsp_skipped,
   input logic [CNT_W-1:0]  rsp_level,
   input logic [CNT_W-1:0]  rsp_space
);

   // stalled response beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid &&
      $stable({rsp_data_out, rsp_ok, rsp_skipped, rsp_level, rsp_space}))
      else $error("response beat changed while stalled");

   // no byte returned without ok
   a_data_needs_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ok |-> rsp_data_out == '0)
      else $error("data without ok");

   // a skip never reports ok or data
   a_skip_alone: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_skipped != '0) |-> !rsp_ok && (rsp_data_out == '0))
      else $error("skip result carries ok or data");

   // level plus space, the ring size, is never zero
   a_size_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_level + rsp_space) != 0)
      else $error("level plus space is zero");

endmodule

bind byte_ring_fifo_with_peek_skip_top brf_checker u_brf_checker (.*);

FILE: sim/byte_ring_fifo_with_peek_skip_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// byte_ring_fifo_with_peek_skip_top_tb
// Self-checking bench for the byte ring FIFO. A directed table covers empty
// and full rings, out-of-range peeks, saturating skips, skip-to wrap and the
// odd size settings. Random phases follow, one ring size per phase. Every
// result beat is held to a typed-in result or a cycle-free software ring image.
// ----------------------------------------------------------------------------
module byte_ring_fifo_with_peek_skip_top_tb;
   import brf_pkg::*;

   localparam int DEPTH         = DEPTH_DEFAULT;
   localparam int OPV_MAX       = 4096;
   localparam int NUM_PHASES    = 12;
   localparam int SETTLE_CYCLES = 20;
   localparam int QUIET_LIMIT   = 4000;
   localparam int HOLD_AT       = 500;
   localparam int HOLD_CYCLES   = 120;

   // action codes with no function in the block
   localparam logic [ACT_W-1:0] ACT_SPARE_6 = 3'd6;
   localparam logic [ACT_W-1:0] ACT_SPARE_7 = 3'd7;

   typedef struct packed {
      logic [BYTE_W-1:0] data_out;
      logic              ok;
      logic [CNT_W-1:0]  skipped;
      logic [CNT_W-1:0]  level;
      logic [CNT_W-1:0]  space;
   } ring_result_type;

   typedef enum logic {ROW_OP, ROW_SIZE} row_kind_type;

   typedef struct {
      row_kind_type      kind;
      logic [ACT_W-1:0]  act;
      logic [BYTE_W-1:0] din;
      logic [CNT_W-1:0]  opv;
      bit                typed;
      ring_result_type   want;
   } stim_row_type;

   // dut ports
   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [ACT_W-1:0]      req_action = '0;
   logic [BYTE_W-1:0]     req_data_in = '0;
   logic [CNT_W-1:0]      req_operand_value = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [BYTE_W-1:0]     rsp_data_out;
   logic                  rsp_ok;
   logic [CNT_W-1:0]      rsp_skipped;
   logic [CNT_W-1:0]      rsp_level;
   logic [CNT_W-1:0]      rsp_space;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   // ring image
   logic [BYTE_W-1:0] ring_bytes [DEPTH];
   int unsigned       rd_slot;
   int unsigned       wr_slot;
   int unsigned       fill_level;
   logic [CNT_W-1:0]  size_reg;

   // bookkeeping
   ring_result_type pending_results [$];
   stim_row_type    stim_rows [$];
   ring_result_type beat_got;
   ring_result_type beat_want;
   int           errors = 0;
   int           ops_sent = 0;
   int           rsp_beats = 0;
   int           sizes_written = 0;
   int           drops = 0;
   int           misses = 0;
   int           skipped_total = 0;
   bit           idle_on = 1'b1;
   bit           hold_done = 1'b0;
   int           hold_left = 0;
   int           stall_left = 0;
   int           quiet_cycles = 0;
   int           phase_size [NUM_PHASES];
   int           phase_len [NUM_PHASES];
   int           phase_push [NUM_PHASES];
   bit           phase_idle [NUM_PHASES];

   byte_ring_fifo_with_peek_skip_top uut (.*);

   // 2 ns clock
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // slots in use, with zero and oversize settings folded in
   function automatic int unsigned ring_span();
      if (size_reg == 0) return 1;
      if (size_reg > DEPTH) return DEPTH;
      return size_reg;
   endfunction

   function automatic int unsigned ring_wrap(int unsigned a, int unsigned b,
                                             int unsigned span);
      int unsigned s;
      s = a + b;
      if (s >= span) s -= span;
      return s;
   endfunction

   // drop up to n bytes from the read side, returns how many went
   function automatic int unsigned ring_discard(int unsigned n, int unsigned span);
      if (n > fill_level) n = fill_level;
      rd_slot = ring_wrap(rd_slot, n, span);
      fill_level -= n;
      skipped_total += n;
      return n;
   endfunction

   // apply one operation to the ring image and return its result beat
   function automatic ring_result_type ring_predict(logic [ACT_W-1:0] act,
                                                    logic [BYTE_W-1:0] din,
                                                    logic [CNT_W-1:0] opv);
      int unsigned     span;
      int unsigned     target;
      int unsigned     gap_to;
      ring_result_type res;
      span = ring_span();
      res = '0;
      case (act)
         ACT_PUSH: begin
            if (fill_level < span) begin
               ring_bytes[wr_slot] = din;
               wr_slot = ring_wrap(wr_slot, 1, span);
               fill_level++;
               res.ok = 1'b1;
            end else begin
               drops++;
            end
         end
         ACT_POP: begin
            if (fill_level > 0) begin
               res.data_out = ring_bytes[rd_slot];
               rd_slot = ring_wrap(rd_slot, 1, span);
               fill_level--;
               res.ok = 1'b1;
            end else begin
               misses++;
            end
         end
         ACT_PEEK: begin
            if (opv < fill_level) begin
               res.data_out = ring_bytes[ring_wrap(rd_slot, opv, span)];
               res.ok = 1'b1;
            end else begin
               misses++;
            end
         end
         ACT_SKIP: begin
            res.skipped = CNT_W'(ring_discard(opv, span));
         end
         ACT_SKIP_TO: begin
            target = opv % span;
            gap_to = (target >= rd_slot) ? target - rd_slot : target + span - rd_slot;
            res.skipped = CNT_W'(ring_discard(gap_to, span));
         end
         ACT_CLEAR: begin
            rd_slot = 0;
            wr_slot = 0;
            fill_level = 0;
         end
         default: begin
         end
      endcase
      res.level = CNT_W'(fill_level);
      res.space = CNT_W'(span - fill_level);
      return res;
   endfunction

   // table rows: plain, with a typed-in result, and a size change
   function automatic stim_row_type op(logic [ACT_W-1:0] act, logic [BYTE_W-1:0] din,
                                       logic [CNT_W-1:0] opv);
      stim_row_type row;
      row.kind = ROW_OP;
      row.act = act;
      row.din = din;
      row.opv = opv;
      row.typed = 1'b0;
      row.want = '0;
      return row;
   endfunction

   function automatic stim_row_type op_exp(logic [ACT_W-1:0] act, logic [BYTE_W-1:0] din,
                                           logic [CNT_W-1:0] opv, logic [BYTE_W-1:0] dout,
                                           logic ok, int skp, int lvl, int spc);
      stim_row_type row;
      row = op(act, din, opv);
      row.typed = 1'b1;
      row.want = '{dout, ok, CNT_W'(skp), CNT_W'(lvl), CNT_W'(spc)};
      return row;
   endfunction

   function automatic stim_row_type resize(logic [CNT_W-1:0] value);
      stim_row_type row;
      row = op(ACT_PUSH, '0, value);
      row.kind = ROW_SIZE;
      return row;
   endfunction

   task automatic report_field(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
         $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want, got);
         errors++;
      end
   endtask

   // offer one request beat, wait for it to be taken, then log its result
   task automatic send_op(logic [ACT_W-1:0] act, logic [BYTE_W-1:0] din,
                          logic [CNT_W-1:0] opv, bit typed, ring_result_type want);
      ring_result_type pred;
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_action <= act;
      req_data_in <= din;
      req_operand_value <= opv;
      do @(posedge clock); while (req_stall);
      pred = ring_predict(act, din, opv);
      pending_results.push_back(typed ? want : pred);
      ops_sent++;
   endtask

   // stop offering and let every outstanding result come back
   task automatic drain_results();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // write the size register, read it back, and empty the ring image
   task automatic set_ring_size(logic [CNT_W-1:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= CSR_ADDR_W'(4 * REG_RING_SIZE);
      csr_pwdata <= CSR_DATA_W'(value);
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata !== CSR_DATA_W'(value)) begin
         $display("%0t ns: ring_size readback mismatch, expected %0d, got %0d",
                  $time, value, csr_prdata);
         errors++;
      end
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      size_reg = value;
      rd_slot = 0;
      wr_slot = 0;
      fill_level = 0;
      sizes_written++;
   endtask

   // result side: check each beat, then pick the next stall
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            beat_got = {rsp_data_out, rsp_ok, rsp_skipped, rsp_level, rsp_space};
            rsp_beats++;
            if (pending_results.size() == 0) begin
               $display("%0t ns: unexpected result beat, expected none, got level %0d",
                        $time, rsp_level);
               errors++;
            end else begin
               beat_want = pending_results.pop_front();
               report_field("data_out", beat_want.data_out, beat_got.data_out);
               report_field("ok", beat_want.ok, beat_got.ok);
               report_field("skipped", beat_want.skipped, beat_got.skipped);
               report_field("level", beat_want.level, beat_got.level);
               report_field("space", beat_want.space, beat_got.space);
            end
         end
         // one long hold-off so the request side backs up
         if (rsp_beats >= HOLD_AT && !hold_done) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else if (idle_on && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 6);
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // watchdog on cycles with no beat moving anywhere
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_psel && csr_penable)) begin
         quiet_cycles = 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("%0t ns: no beat moved for %0d cycles", $time, quiet_cycles);
         $display("byte_ring_fifo_with_peek_skip_top_tb: errors");
         $finish;
      end else begin
         quiet_cycles++;
      end
   end

   // stimulus
   initial begin
      int unsigned       span;
      int unsigned       hi;
      int                pick;
      logic [ACT_W-1:0]  act;
      logic [BYTE_W-1:0] din;
      logic [CNT_W-1:0]  opv;

      size_reg = RING_SIZE_RESET;
      rd_slot = 0;
      wr_slot = 0;
      fill_level = 0;

      // directed rows, reset size first
      stim_rows.push_back(op_exp(ACT_POP, 8'h00, 13'd0, 8'h00, 1'b0, 0, 0, 4096));
      stim_rows.push_back(op_exp(ACT_PEEK, 8'hFF, 13'd4096, 8'h00, 1'b0, 0, 0, 4096));
      stim_rows.push_back(op_exp(ACT_SKIP, 8'h00, 13'd4096, 8'h00, 1'b0, 0, 0, 4096));
      stim_rows.push_back(op_exp(ACT_PUSH, 8'hFF, 13'd0, 8'h00, 1'b1, 0, 1, 4095));
      stim_rows.push_back(op_exp(ACT_PUSH, 8'h00, 13'd4096, 8'h00, 1'b1, 0, 2, 4094));
      stim_rows.push_back(op(ACT_PUSH, 8'h5A, 13'd0));
      stim_rows.push_back(op(ACT_PEEK, 8'h00, 13'd1));
      stim_rows.push_back(op_exp(ACT_PEEK, 8'h00, 13'd3, 8'h00, 1'b0, 0, 3, 4093));
      stim_rows.push_back(op(ACT_POP, 8'h00, 13'd0));
      // target behind the read point wraps forward, saturates at the fill
      stim_rows.push_back(op(ACT_SKIP_TO, 8'h00, 13'd0));
      stim_rows.push_back(op_exp(ACT_SPARE_6, 8'hFF, 13'd4096, 8'h00, 1'b0, 0, 0, 4096));
      stim_rows.push_back(op_exp(ACT_SPARE_7, 8'hFF, 13'd4096, 8'h00, 1'b0, 0, 0, 4096));
      stim_rows.push_back(op(ACT_PUSH, 8'h81, 13'd0));
      stim_rows.push_back(op_exp(ACT_CLEAR, 8'h00, 13'd0, 8'h00, 1'b0, 0, 0, 4096));
      // two-slot ring, push when full
      stim_rows.push_back(resize(13'd2));
      stim_rows.push_back(op_exp(ACT_PUSH, 8'h11, 13'd0, 8'h00, 1'b1, 0, 1, 1));
      stim_rows.push_back(op_exp(ACT_PUSH, 8'h22, 13'd0, 8'h00, 1'b1, 0, 2, 0));
      stim_rows.push_back(op_exp(ACT_PUSH, 8'h33, 13'd0, 8'h00, 1'b0, 0, 2, 0));
      stim_rows.push_back(op(ACT_SKIP_TO, 8'h00, 13'd1));
      stim_rows.push_back(op(ACT_POP, 8'h00, 13'd0));
      // zero size acts as one slot, target at the read point skips nothing
      stim_rows.push_back(resize(13'd0));
      stim_rows.push_back(op_exp(ACT_PUSH, 8'h7E, 13'd0, 8'h00, 1'b1, 0, 1, 0));
      stim_rows.push_back(op_exp(ACT_PUSH, 8'h01, 13'd0, 8'h00, 1'b0, 0, 1, 0));
      stim_rows.push_back(op(ACT_SKIP_TO, 8'h00, 13'd4096));
      // oversize setting folds to the full store
      stim_rows.push_back(resize(13'd8191));
      stim_rows.push_back(op_exp(ACT_PUSH, 8'hC3, 13'd0, 8'h00, 1'b1, 0, 1, 4095));
      stim_rows.push_back(op_exp(ACT_SKIP, 8'h00, 13'd0, 8'h00, 1'b0, 0, 1, 4095));
      stim_rows.push_back(op(ACT_SKIP, 8'h00, 13'd4096));

      // random phases: size, length, push share, idling
      phase_size = '{4096, 1, 2, 16, 0, 8191, 3, 0, 4097, 0, 7, 4096};
      phase_len  = '{150, 120, 120, 200, 80, 150, 150, 200, 120, 200, 180, 180};
      phase_push = '{70, 45, 45, 55, 50, 60, 50, 55, 55, 60, 50, 52};
      phase_idle = '{1, 1, 0, 1, 1, 1, 1, 1, 0, 1, 1, 0};
      phase_size[7] = $urandom_range(4, 64);
      phase_size[9] = $urandom_range(65, 4095);

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // walk the directed table
      foreach (stim_rows[i]) begin
         if (stim_rows[i].kind == ROW_SIZE) begin
            drain_results();
            set_ring_size(stim_rows[i].opv);
         end else begin
            send_op(stim_rows[i].act, stim_rows[i].din, stim_rows[i].opv,
                    stim_rows[i].typed, stim_rows[i].want);
         end
      end

      // random traffic, one ring size per phase
      for (int p = 0; p < NUM_PHASES; p++) begin
         drain_results();
         set_ring_size(CNT_W'(phase_size[p]));
         idle_on = phase_idle[p];
         repeat (phase_len[p]) begin
            span = ring_span();
            din = $urandom_range(0, 255);
            opv = CNT_W'($urandom_range(0, OPV_MAX));
            pick = $urandom_range(0, 99);
            if (pick < phase_push[p]) begin
               act = ACT_PUSH;
            end else begin
               pick = $urandom_range(0, 99);
               if (pick < 40) act = ACT_POP;
               else if (pick < 68) act = ACT_PEEK;
               else if (pick < 80) act = ACT_SKIP;
               else if (pick < 94) act = ACT_SKIP_TO;
               else if (pick < 97) act = ACT_CLEAR;
               else act = pick[0] ? ACT_SPARE_7 : ACT_SPARE_6;
            end
            // operands mostly near the fill level or inside the ring
            case (act)
               ACT_PEEK: begin
                  hi = (fill_level + 1 > OPV_MAX) ? OPV_MAX : fill_level + 1;
                  if ($urandom_range(0, 3) != 0) opv = CNT_W'($urandom_range(0, hi));
               end
               ACT_SKIP: begin
                  hi = fill_level / 2 + 2;
                  if ($urandom_range(0, 9) < 7) opv = CNT_W'($urandom_range(0, hi));
               end
               ACT_SKIP_TO: begin
                  pick = $urandom_range(0, 19);
                  hi = (2 * span > OPV_MAX) ? OPV_MAX : 2 * span;
                  if (pick < 14) opv = CNT_W'($urandom_range(0, span - 1));
                  else if (pick < 17) opv = CNT_W'($urandom_range(span, hi));
               end
               default: begin
               end
            endcase
            send_op(act, din, opv, 1'b0, '0);
         end
      end

      drain_results();
      $display("covered %0d operations over %0d size settings, %0d result beats checked",
               ops_sent, sizes_written, rsp_beats);
      $display("full-ring drops %0d, pop/peek misses %0d, bytes skipped %0d",
               drops, misses, skipped_total);
      if (errors == 0) begin
         $display("byte_ring_fifo_with_peek_skip_top_tb: clean");
      end else begin
         $display("byte_ring_fifo_with_peek_skip_top_tb: errors");
      end
      $finish;
   end

endmodule
